// ===== rtl/kss_pkg.sv =====
// package for the keyed sorted set table: opcodes, status codes, sizes
// no dependencies
package kss_pkg;
  localparam int NUM_SETS_DEF = 64;
  localparam int MAX_MEMBERS_DEF = 64;
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_CLEAR = 3'd2;
  localparam logic [2:0] OP_QUERY = 3'd3;
  localparam logic [2:0] OP_READ = 3'd4;
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NO_SLOT = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_BAD = 3'd4;
endpackage

// ===== rtl/keyed_sorted_set_table_core.sv =====
// keyed sorted set table top level: slot table, sequencer, member store
// depends on kss_pkg and kss_mem
//
// one request at a time. after reset a clearing pass frees every slot, one
// slot a cycle, with s_tready low. a request with a nonzero key and a known
// op first scans the slot table through registered reads, one slot a cycle.
// on a hit, add, remove and query then walk the sorted member list through
// the single read port of the member store, one entry at a time in a read
// state and a compare state, to find the place of the entity. add shifts the
// tail up from the end, one entry per read and write state, and remove
// shifts it down. a remove of the main member goes through S_M0RD and S_M0
// to fetch the new smallest member. the key scan plus the list walk and
// shift set the worst case from acceptance to the result. the result sits
// in an output register and s_tready stays low from acceptance until that
// result has been taken. main members and the member store hold garbage
// until written and are only read below count.
module keyed_sorted_set_table_core #(
  parameter int NUM_SETS = kss_pkg::NUM_SETS_DEF,
  parameter int MAX_MEMBERS = kss_pkg::MAX_MEMBERS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // op[2:0], set_key[34:3], entity[98:35], position[104:99], zero fill
  input  logic [111:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[2:0], found[3], member_count[10:4], main_member[74:11],
  // member_value[138:75], zero fill
  output logic [143:0] m_tdata
);
  import kss_pkg::*;
  localparam int SW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int MW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
  localparam int CW = $clog2(MAX_MEMBERS + 1);
  localparam int AW = SW + MW;

  localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_DISP = 4'd2,
    S_FRD = 4'd3, S_FCMP = 4'd4, S_DEC = 4'd5, S_UPRD = 4'd6, S_UPWR = 4'd7,
    S_DNRD = 4'd8, S_DNWR = 4'd9, S_M0RD = 4'd10, S_M0 = 4'd11,
    S_RDW = 4'd12, S_OUT = 4'd13, S_CLR = 4'd14;

  logic [3:0] state;
  logic [31:0] slot_keys [NUM_SETS];
  logic [CW-1:0] slot_counts [NUM_SETS];
  logic [63:0] slot_main [NUM_SETS];

  // registered slot table reads at the scan index
  logic [31:0] key_rd;
  logic [CW-1:0] cnt_rd;
  logic [63:0] main_rd;

  // latched request
  logic [2:0] op;
  logic [31:0] key;
  logic [63:0] ent;
  logic [5:0] pos;
  // scan state
  logic [SW:0] idx;
  logic scan_v;
  logic [SW-1:0] scan_i;
  logic hit, has_free;
  logic [SW-1:0] hit_slot, free_slot;
  logic [CW-1:0] hit_n;
  logic [63:0] hit_main;
  // list walk state
  logic [CW-1:0] n, p, j;
  logic [SW-1:0] sl;
  logic [63:0] smain;
  // result
  logic [2:0] status;
  logic found;
  logic [6:0] rcount;
  logic [63:0] rmain, rvalue;

  // member store port
  logic we;
  logic [MW-1:0] wi, ri;
  logic [63:0] wdata, rdata;
  kss_mem #(.AW(AW)) u_mem (.clk(clk), .we(we), .waddr({sl, wi}), .wdata(wdata),
    .raddr({sl, ri}), .rdata(rdata));

  // read index and write port by state
  always_comb begin
    we = 1'b0;
    wi = p[MW-1:0];
    wdata = ent;
    ri = p[MW-1:0];
    unique case (state)
      S_UPRD:  begin
        ri = MW'(j - CW'(1));
        // write new entity at its place
        if (j == p) begin we = 1'b1; wi = p[MW-1:0]; wdata = ent; end
      end
      S_UPWR:  begin we = 1'b1; wi = j[MW-1:0]; wdata = rdata; end
      S_DNRD:  ri = MW'(j + CW'(1));
      S_DNWR:  begin we = 1'b1; wi = j[MW-1:0]; wdata = rdata; end
      S_M0RD:  ri = '0;
      S_RDW:   ri = pos[MW-1:0];
      S_DEC:   begin we = (op == OP_ADD) && (n == CW'(0)); wi = '0; end
      default: ri = p[MW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      idx <= '0;
    end else begin
      unique case (state)
        // clearing pass: free one slot a cycle
        S_CLR: begin
          slot_keys[idx[SW-1:0]] <= '0;
          slot_counts[idx[SW-1:0]] <= '0;
          if (idx == (SW+1)'(NUM_SETS - 1)) state <= S_IDLE;
          idx <= idx + (SW+1)'(1);
        end
        S_IDLE: if (s_tvalid) begin
          op <= s_tdata[2:0];
          key <= s_tdata[34:3];
          ent <= s_tdata[98:35];
          pos <= s_tdata[104:99];
          idx <= '0; scan_v <= 1'b0; hit <= 1'b0; has_free <= 1'b0;
          status <= ST_OK; found <= 1'b0; rcount <= '0;
          rmain <= '0; rvalue <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (key == 32'd0 || op > OP_READ) begin
            status <= ST_BAD; state <= S_OUT;
          end else begin
            // compare the slot read in the previous cycle
            if (scan_v && !hit && key_rd == key) begin
              hit <= 1'b1; hit_slot <= scan_i; hit_n <= cnt_rd; hit_main <= main_rd;
            end
            if (scan_v && !has_free && key_rd == 32'd0) begin
              has_free <= 1'b1; free_slot <= scan_i;
            end
            if (idx == (SW+1)'(NUM_SETS)) begin
              scan_v <= 1'b0; state <= S_DISP;
            end else begin
              scan_v <= 1'b1; scan_i <= idx[SW-1:0];
              idx <= idx + (SW+1)'(1);
            end
          end
        end
        S_DISP: begin
          p <= '0;
          if (hit) begin
            sl <= hit_slot; n <= hit_n; smain <= hit_main;
            priority case (op)
              OP_CLEAR: begin
                slot_keys[hit_slot] <= '0; slot_counts[hit_slot] <= '0;
                state <= S_OUT;
              end
              OP_READ: state <= S_RDW;
              default: state <= S_FRD;
            endcase
          end else if (op == OP_ADD) begin
            if (has_free) begin
              sl <= free_slot; n <= '0; smain <= ent;
              slot_keys[free_slot] <= key;
              slot_counts[free_slot] <= CW'(1);
              slot_main[free_slot] <= ent;
              state <= S_DEC;
            end else begin
              status <= ST_NO_SLOT; state <= S_OUT;
            end
          end else begin
            status <= ST_UNKNOWN; state <= S_OUT;
          end
        end
        S_FRD: state <= (p < n) ? S_FCMP : S_DEC;
        S_FCMP: begin
          if (rdata < ent) begin
            p <= p + CW'(1); state <= S_FRD;
          end else begin
            found <= (rdata == ent); state <= S_DEC;
          end
        end
        S_DEC: begin
          // a newly opened slot holds one member
          rcount <= (n == CW'(0)) ? 7'd1 : 7'(n);
          rmain <= smain;
          state <= S_OUT;
          if (op == OP_QUERY) begin
            found <= found && (p < n);
          end else begin
            found <= 1'b0;
            if (op == OP_ADD && n != CW'(0) && !(found && p < n)) begin
              if (n >= CW'(MAX_MEMBERS)) status <= ST_FULL;
              else begin j <= n; state <= S_UPRD; end
            end else if (op == OP_REMOVE && found && p < n) begin
              j <= p; state <= S_DNRD;
            end
          end
        end
        S_UPRD: if (j == p) begin
          slot_counts[sl] <= n + CW'(1);
          rcount <= 7'(n + CW'(1));
          state <= S_OUT;
        end else state <= S_UPWR;
        S_UPWR: begin
          j <= j - CW'(1); state <= S_UPRD;
        end
        S_DNRD: if (j + CW'(1) >= n) begin
          slot_counts[sl] <= n - CW'(1);
          rcount <= 7'(n - CW'(1));
          if (n == CW'(1)) begin
            slot_keys[sl] <= '0; rmain <= '0; state <= S_OUT;
          end else if (smain == ent) state <= S_M0RD;
          else state <= S_OUT;
        end else state <= S_DNWR;
        S_DNWR: begin
          j <= j + CW'(1); state <= S_DNRD;
        end
        S_M0RD: state <= S_M0;
        // read result, or the new main member after a remove
        S_M0: begin
          if (op == OP_READ) rvalue <= rdata;
          else begin
            slot_main[sl] <= rdata; rmain <= rdata;
          end
          state <= S_OUT;
        end
        S_RDW: begin
          rcount <= 7'(n); rmain <= smain;
          if (CW'(pos) < n && {1'b0, pos} < 7'(MAX_MEMBERS)) state <= S_M0;
          else begin status <= ST_BAD; state <= S_OUT; end
        end
        S_OUT: if (m_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      key_rd <= slot_keys[idx[SW-1:0]];
      cnt_rd <= slot_counts[idx[SW-1:0]];
      main_rd <= slot_main[idx[SW-1:0]];
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata = {5'd0, rvalue, rmain, rcount, found, status};

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> rcount <= 7'(MAX_MEMBERS)) else $error("count overflow");
endmodule

// ===== rtl/kss_mem.sv =====
// member store: one write and one registered read port
// depends on nothing
module kss_mem #(
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [63:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [63:0]   rdata
);
  logic [63:0] mem [(1<<AW)];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
